// File: rtl/kf3_pkg.sv
// ----------------------------------------------------------------------------
// kf3_pkg
// shared types, constants and the step microprogram of the three-state filter
// ----------------------------------------------------------------------------
package kf3_pkg;

    localparam int KF3_STATE_WIDTH = 48;
    localparam int KF3_FRAC_BITS   = 24;
    localparam int KF3_CFG_W       = 47;
    localparam int KF3_CFG_IDX_W   = 2;
    localparam int KF3_MEAS_W      = 32;
    localparam int KF3_ADDR_W      = 6;
    localparam int KF3_DEPTH       = 38;
    localparam int KF3_STEP_W      = 6;

    // register indexes of the configuration port
    localparam logic [KF3_CFG_IDX_W-1:0] CFG_MEAS_NOISE = 2'd0;
    localparam logic [KF3_CFG_IDX_W-1:0] CFG_PROC_NOISE = 2'd1;

    localparam logic [KF3_CFG_W-1:0] MEAS_NOISE_RST = 47'd16777216000;
    localparam logic [KF3_CFG_W-1:0] PROC_NOISE_RST = 47'd16777216;

    // scratch memory map
    localparam logic [KF3_ADDR_W-1:0] A_X0    = 6'd0;
    localparam logic [KF3_ADDR_W-1:0] A_X1    = 6'd1;
    localparam logic [KF3_ADDR_W-1:0] A_X2    = 6'd2;
    localparam logic [KF3_ADDR_W-1:0] A_P0    = 6'd3;
    localparam logic [KF3_ADDR_W-1:0] A_P1    = 6'd4;
    localparam logic [KF3_ADDR_W-1:0] A_P2    = 6'd5;
    localparam logic [KF3_ADDR_W-1:0] A_P3    = 6'd6;
    localparam logic [KF3_ADDR_W-1:0] A_P4    = 6'd7;
    localparam logic [KF3_ADDR_W-1:0] A_P5    = 6'd8;
    localparam logic [KF3_ADDR_W-1:0] A_P6    = 6'd9;
    localparam logic [KF3_ADDR_W-1:0] A_P7    = 6'd10;
    localparam logic [KF3_ADDR_W-1:0] A_P8    = 6'd11;
    localparam logic [KF3_ADDR_W-1:0] A_Z     = 6'd12;
    localparam logic [KF3_ADDR_W-1:0] A_Q     = 6'd13;
    localparam logic [KF3_ADDR_W-1:0] A_R     = 6'd14;
    localparam logic [KF3_ADDR_W-1:0] A_XP0   = 6'd15;
    localparam logic [KF3_ADDR_W-1:0] A_XP1   = 6'd16;
    localparam logic [KF3_ADDR_W-1:0] A_FP0   = 6'd17;
    localparam logic [KF3_ADDR_W-1:0] A_FP1   = 6'd18;
    localparam logic [KF3_ADDR_W-1:0] A_FP2   = 6'd19;
    localparam logic [KF3_ADDR_W-1:0] A_FP3   = 6'd20;
    localparam logic [KF3_ADDR_W-1:0] A_FP4   = 6'd21;
    localparam logic [KF3_ADDR_W-1:0] A_FP5   = 6'd22;
    localparam logic [KF3_ADDR_W-1:0] A_PP0   = 6'd23;
    localparam logic [KF3_ADDR_W-1:0] A_PP1   = 6'd24;
    localparam logic [KF3_ADDR_W-1:0] A_PP3   = 6'd26;
    localparam logic [KF3_ADDR_W-1:0] A_PP4   = 6'd27;
    localparam logic [KF3_ADDR_W-1:0] A_PP6   = 6'd29;
    localparam logic [KF3_ADDR_W-1:0] A_PP7   = 6'd30;
    localparam logic [KF3_ADDR_W-1:0] A_PP8   = 6'd31;
    localparam logic [KF3_ADDR_W-1:0] A_DEN   = 6'd32;
    localparam logic [KF3_ADDR_W-1:0] A_INNOV = 6'd33;
    localparam logic [KF3_ADDR_W-1:0] A_G0    = 6'd34;
    localparam logic [KF3_ADDR_W-1:0] A_G1    = 6'd35;
    localparam logic [KF3_ADDR_W-1:0] A_G2    = 6'd36;
    localparam logic [KF3_ADDR_W-1:0] A_T     = 6'd37;

    typedef enum logic [2:0] {
        OP_LDZ,
        OP_LDQ,
        OP_LDR,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_OUT
    } kf3_op_t;

    typedef struct packed {
        kf3_op_t               op;
        logic [KF3_ADDR_W-1:0] dst;
        logic [KF3_ADDR_W-1:0] a;
        logic [KF3_ADDR_W-1:0] b;
    } kf3_uop_t;

    typedef struct packed {
        logic    start;
        kf3_op_t op;
    } arith_req_t;

    typedef struct packed {
        logic done;
        logic sat;
    } arith_rsp_t;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_ISSUE,
        SQ_EXEC,
        SQ_WAIT
    } seq_state_t;

    typedef enum logic [2:0] {
        AR_IDLE,
        AR_MULP,
        AR_MULA,
        AR_MULF,
        AR_DIV,
        AR_DIVF,
        AR_DONE
    } arith_state_t;

    localparam logic [KF3_STEP_W-1:0] LAST_STEP = 6'd49;

    function automatic kf3_uop_t kf3_uop(input logic [KF3_STEP_W-1:0] step);
        kf3_uop_t u;
        u = '{op: OP_OUT, dst: A_X0, a: A_X0, b: A_X0};
        case (step)
            6'd0:  u = '{op: OP_LDZ, dst: A_Z,     a: A_X0,  b: A_X0};
            6'd1:  u = '{op: OP_LDQ, dst: A_Q,     a: A_X0,  b: A_X0};
            6'd2:  u = '{op: OP_LDR, dst: A_R,     a: A_X0,  b: A_X0};
            // prediction of the state
            6'd3:  u = '{op: OP_ADD, dst: A_XP0,   a: A_X0,  b: A_X1};
            6'd4:  u = '{op: OP_ADD, dst: A_XP1,   a: A_X1,  b: A_X2};
            // F*P
            6'd5:  u = '{op: OP_ADD, dst: A_FP0,   a: A_P0,  b: A_P3};
            6'd6:  u = '{op: OP_ADD, dst: A_FP1,   a: A_P1,  b: A_P4};
            6'd7:  u = '{op: OP_ADD, dst: A_FP2,   a: A_P2,  b: A_P5};
            6'd8:  u = '{op: OP_ADD, dst: A_FP3,   a: A_P3,  b: A_P6};
            6'd9:  u = '{op: OP_ADD, dst: A_FP4,   a: A_P4,  b: A_P7};
            6'd10: u = '{op: OP_ADD, dst: A_FP5,   a: A_P5,  b: A_P8};
            // (F*P)*F' + q*I
            6'd11: u = '{op: OP_ADD, dst: A_PP0,   a: A_FP0, b: A_FP1};
            6'd12: u = '{op: OP_ADD, dst: A_PP0,   a: A_PP0, b: A_Q};
            6'd13: u = '{op: OP_ADD, dst: A_PP1,   a: A_FP1, b: A_FP2};
            6'd14: u = '{op: OP_ADD, dst: A_PP3,   a: A_FP3, b: A_FP4};
            6'd15: u = '{op: OP_ADD, dst: A_PP4,   a: A_FP4, b: A_FP5};
            6'd16: u = '{op: OP_ADD, dst: A_PP4,   a: A_PP4, b: A_Q};
            6'd17: u = '{op: OP_ADD, dst: A_PP6,   a: A_P6,  b: A_P7};
            6'd18: u = '{op: OP_ADD, dst: A_PP7,   a: A_P7,  b: A_P8};
            6'd19: u = '{op: OP_ADD, dst: A_PP8,   a: A_P8,  b: A_Q};
            // gain
            6'd20: u = '{op: OP_ADD, dst: A_DEN,   a: A_PP0, b: A_R};
            6'd21: u = '{op: OP_SUB, dst: A_INNOV, a: A_Z,   b: A_XP0};
            6'd22: u = '{op: OP_DIV, dst: A_G0,    a: A_PP0, b: A_DEN};
            6'd23: u = '{op: OP_DIV, dst: A_G1,    a: A_PP3, b: A_DEN};
            6'd24: u = '{op: OP_DIV, dst: A_G2,    a: A_PP6, b: A_DEN};
            // state update
            6'd25: u = '{op: OP_MUL, dst: A_T,     a: A_G0,  b: A_INNOV};
            6'd26: u = '{op: OP_ADD, dst: A_X0,    a: A_XP0, b: A_T};
            6'd27: u = '{op: OP_MUL, dst: A_T,     a: A_G1,  b: A_INNOV};
            6'd28: u = '{op: OP_ADD, dst: A_X1,    a: A_XP1, b: A_T};
            6'd29: u = '{op: OP_MUL, dst: A_T,     a: A_G2,  b: A_INNOV};
            6'd30: u = '{op: OP_ADD, dst: A_X2,    a: A_X2,  b: A_T};
            // covariance update
            6'd31: u = '{op: OP_MUL, dst: A_T,     a: A_G0,  b: A_PP0};
            6'd32: u = '{op: OP_SUB, dst: A_P0,    a: A_PP0, b: A_T};
            6'd33: u = '{op: OP_MUL, dst: A_T,     a: A_G0,  b: A_PP1};
            6'd34: u = '{op: OP_SUB, dst: A_P1,    a: A_PP1, b: A_T};
            6'd35: u = '{op: OP_MUL, dst: A_T,     a: A_G0,  b: A_FP2};
            6'd36: u = '{op: OP_SUB, dst: A_P2,    a: A_FP2, b: A_T};
            6'd37: u = '{op: OP_MUL, dst: A_T,     a: A_G1,  b: A_PP0};
            6'd38: u = '{op: OP_SUB, dst: A_P3,    a: A_PP3, b: A_T};
            6'd39: u = '{op: OP_MUL, dst: A_T,     a: A_G1,  b: A_PP1};
            6'd40: u = '{op: OP_SUB, dst: A_P4,    a: A_PP4, b: A_T};
            6'd41: u = '{op: OP_MUL, dst: A_T,     a: A_G1,  b: A_FP2};
            6'd42: u = '{op: OP_SUB, dst: A_P5,    a: A_FP5, b: A_T};
            6'd43: u = '{op: OP_MUL, dst: A_T,     a: A_G2,  b: A_PP0};
            6'd44: u = '{op: OP_SUB, dst: A_P6,    a: A_PP6, b: A_T};
            6'd45: u = '{op: OP_MUL, dst: A_T,     a: A_G2,  b: A_PP1};
            6'd46: u = '{op: OP_SUB, dst: A_P7,    a: A_PP7, b: A_T};
            6'd47: u = '{op: OP_MUL, dst: A_T,     a: A_G2,  b: A_FP2};
            6'd48: u = '{op: OP_SUB, dst: A_P8,    a: A_PP8, b: A_T};
            default: u = '{op: OP_OUT, dst: A_X0,  a: A_X0,  b: A_X0};
        endcase
        return u;
    endfunction

endpackage

// File: rtl/kf3_if.sv
// ----------------------------------------------------------------------------
// kf3 channel interfaces
// valid/ready channels for measurements, estimates and register writes
// ----------------------------------------------------------------------------
interface kf3_meas_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] measurement;

    modport source (output valid, output measurement, input ready);
    modport sink   (input valid, input measurement, output ready);
endinterface

interface kf3_est_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] position_estimate;
    logic               saturated;

    modport source (output valid, output position_estimate, output saturated, input ready);
    modport sink   (input valid, input position_estimate, input saturated, output ready);
endinterface

interface kf3_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [46:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/kalman_filter_3state.sv
// ----------------------------------------------------------------------------
// kalman_filter_3state
// position/velocity/acceleration tracker, one measurement per beat
// ----------------------------------------------------------------------------
//  channel | dir | payload                          | beat
//  meas    | in  | measurement (Q16.16)             | one step of the filter
//  est     | out | position_estimate (Q16.16), sat  | one result per step
//  cfg     | in  | index, data (Q24.24 noise regs)  | one register write
//
//  one step runs a fixed 50-entry microprogram through a single arithmetic
//  unit, one micro-op at a time; multiplies work on 32-bit chunks of the
//  operands and each divide runs as a serial restoring division.
//  meas is ready only while the sequencer idles; est has its own output
//  register, so a new beat is taken while the last estimate waits
//  reset clears state and covariance through per-entry valid bits (no sweep)
//  cfg is always ready
// ----------------------------------------------------------------------------
module kalman_filter_3state
    import kf3_pkg::*;
#(
    parameter int STATE_WIDTH = KF3_STATE_WIDTH
) (
    input  logic         clk,
    input  logic         rst_n,
    kf3_meas_if.sink     meas,
    kf3_est_if.source    est,
    kf3_cfg_if.sink      cfg
);

    localparam int W = STATE_WIDTH;

    // saturation limits held in a wide signed lane for the port conversions
    localparam logic signed [65:0] VMAX_X = {{(67 - W){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [65:0] VMIN_X = ~VMAX_X;
    localparam logic signed [65:0] OMAX_X = 66'sd2147483647;
    localparam logic signed [65:0] OMIN_X = -66'sd2147483648;

    // noise registers
    logic [KF3_CFG_W-1:0]  r_cfg_reg;
    logic [KF3_CFG_W-1:0]  q_cfg_reg;

    // sequencer
    seq_state_t            st_reg, st_next;
    logic [KF3_STEP_W-1:0] step_reg, step_next;
    logic                  sat_reg, sat_next;
    logic [KF3_MEAS_W-1:0] meas_reg, meas_next;
    logic [KF3_DEPTH-1:0]  valid_reg, valid_next;
    logic                  rva_reg, rvb_reg;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic signed [31:0]    out_pos_reg, out_pos_next;
    logic                  out_sat_reg, out_sat_next;

    kf3_uop_t              u;
    logic                  we;
    logic [W-1:0]          wdata;
    logic [W-1:0]          rdata_a, rdata_b;
    logic signed [W-1:0]   opnd_a, opnd_b;
    arith_req_t            req;
    arith_rsp_t            rsp;
    logic signed [W-1:0]   ar_result;

    // load-op values
    logic signed [65:0]    z_wide;
    logic signed [W-1:0]   z_val;
    logic                  z_sat;
    logic signed [W-1:0]   r_val, q_val;
    logic                  r_sat, q_sat;

    // estimate narrowing
    logic signed [W-1:0]   y_shift;
    logic signed [65:0]    y_wide;
    logic signed [31:0]    y_val;
    logic                  y_sat;

    assign u = kf3_uop(step_reg);

    kf3_ram #(
        .WIDTH (W),
        .DEPTH (KF3_DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (u.dst),
        .wdata   (wdata),
        .raddr_a (u.a),
        .raddr_b (u.b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    kf3_arith #(
        .W (W)
    ) u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .a      (opnd_a),
        .b      (opnd_b),
        .rsp    (rsp),
        .result (ar_result)
    );

    // never-written entries of x and P read as zero
    assign opnd_a = rva_reg ? $signed(rdata_a) : '0;
    assign opnd_b = rvb_reg ? $signed(rdata_b) : '0;

    // measurement widened to Q24.24
    always_comb
    begin
        z_wide = {{26{meas_reg[31]}}, meas_reg, 8'b0};
        z_sat  = 1'b0;
        if (z_wide > VMAX_X)
        begin
            z_sat = 1'b1;
            z_wide = VMAX_X;
        end
        else if (z_wide < VMIN_X)
        begin
            z_sat = 1'b1;
            z_wide = VMIN_X;
        end
        z_val = z_wide[W-1:0];
    end

    // noise registers clamped to the state range
    always_comb
    begin
        r_sat = ($signed({19'b0, r_cfg_reg}) > VMAX_X);
        q_sat = ($signed({19'b0, q_cfg_reg}) > VMAX_X);
        r_val = r_sat ? VMAX_X[W-1:0] : W'(r_cfg_reg);
        q_val = q_sat ? VMAX_X[W-1:0] : W'(q_cfg_reg);
    end

    // x0 / 256 toward zero, then clamp to Q16.16
    always_comb
    begin
        y_shift = opnd_a >>> 8;
        if (opnd_a[W-1] && (opnd_a[7:0] != 8'b0))
        begin
            y_shift = y_shift + W'(1);
        end
        y_wide = 66'(y_shift);
        y_sat  = 1'b0;
        if (y_wide > OMAX_X)
        begin
            y_sat  = 1'b1;
            y_wide = OMAX_X;
        end
        else if (y_wide < OMIN_X)
        begin
            y_sat  = 1'b1;
            y_wide = OMIN_X;
        end
        y_val = y_wide[31:0];
    end

    // configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_cfg_reg <= MEAS_NOISE_RST;
            q_cfg_reg <= PROC_NOISE_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_MEAS_NOISE: r_cfg_reg <= cfg.data;
                CFG_PROC_NOISE: q_cfg_reg <= cfg.data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= SQ_IDLE;
            step_reg      <= '0;
            sat_reg       <= 1'b0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            step_reg      <= step_next;
            sat_reg       <= sat_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        meas_reg    <= meas_next;
        out_pos_reg <= out_pos_next;
        out_sat_reg <= out_sat_next;
        // valid bits follow the registered read
        rva_reg     <= valid_reg[u.a];
        rvb_reg     <= valid_reg[u.b];
    end

    always_comb
    begin
        st_next        = st_reg;
        step_next      = step_reg;
        sat_next       = sat_reg;
        meas_next      = meas_reg;
        valid_next     = valid_reg;
        out_valid_next = out_valid_reg & ~est.ready;
        out_pos_next   = out_pos_reg;
        out_sat_next   = out_sat_reg;
        we             = 1'b0;
        wdata          = ar_result;
        req.start      = 1'b0;
        req.op         = u.op;
        meas.ready     = 1'b0;

        case (st_reg)
            SQ_IDLE:
            begin
                meas.ready = 1'b1;
                if (meas.valid)
                begin
                    meas_next = meas.measurement;
                    step_next = '0;
                    sat_next  = 1'b0;
                    st_next   = SQ_ISSUE;
                end
            end
            SQ_ISSUE:
            begin
                // read address of this step goes into the memory
                st_next = SQ_EXEC;
            end
            SQ_EXEC:
            begin
                case (u.op)
                    OP_LDZ, OP_LDQ, OP_LDR:
                    begin
                        we = 1'b1;
                        if (u.op == OP_LDZ)
                        begin
                            wdata    = z_val;
                            sat_next = sat_reg | z_sat;
                        end
                        else if (u.op == OP_LDQ)
                        begin
                            wdata    = q_val;
                            sat_next = sat_reg | q_sat;
                        end
                        else
                        begin
                            wdata    = r_val;
                            sat_next = sat_reg | r_sat;
                        end
                        valid_next[u.dst] = 1'b1;
                        step_next = step_reg + 1'b1;
                        st_next   = SQ_ISSUE;
                    end
                    OP_OUT:
                    begin
                        // hold until the output register is free
                        if (!out_valid_reg || est.ready)
                        begin
                            out_valid_next = 1'b1;
                            out_pos_next   = y_val;
                            out_sat_next   = sat_reg | y_sat;
                            st_next        = SQ_IDLE;
                        end
                    end
                    default:
                    begin
                        req.start = 1'b1;
                        st_next   = SQ_WAIT;
                    end
                endcase
            end
            SQ_WAIT:
            begin
                if (rsp.done)
                begin
                    we                = 1'b1;
                    wdata             = ar_result;
                    sat_next          = sat_reg | rsp.sat;
                    valid_next[u.dst] = 1'b1;
                    step_next         = (step_reg == LAST_STEP) ? step_reg
                                                                : step_reg + 1'b1;
                    st_next           = SQ_ISSUE;
                end
            end
            default:
            begin
                st_next = SQ_IDLE;
            end
        endcase
    end

    assign est.valid             = out_valid_reg;
    assign est.position_estimate = out_pos_reg;
    assign est.saturated         = out_sat_reg;

endmodule

// File: rtl/kf3_ram.sv
// ----------------------------------------------------------------------------
// kf3_ram
// generic one-write two-read memory with registered read data
// ----------------------------------------------------------------------------
module kf3_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 38,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// File: rtl/kf3_arith.sv
// ----------------------------------------------------------------------------
// kf3_arith
// shared saturating add/sub, partial-product multiplier and serial divider
// ----------------------------------------------------------------------------
module kf3_arith
    import kf3_pkg::*;
#(
    parameter int W = KF3_STATE_WIDTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  arith_req_t          req,
    input  logic signed [W-1:0] a,
    input  logic signed [W-1:0] b,
    output arith_rsp_t          rsp,
    output logic signed [W-1:0] result
);

    localparam int NCH  = (W + 31) / 32;
    localparam int MW   = NCH * 32;
    localparam int PW   = 2 * MW;
    localparam int DW   = W + KF3_FRAC_BITS;
    localparam int CNTW = $clog2(DW + 1);

    localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
        logic [W-1:0] m;
        m = v[W-1] ? W'(-v) : W'(v);
        return m;
    endfunction

    arith_state_t     st_reg, st_next;
    logic [MW-1:0]    ma_reg, ma_next;
    logic [MW-1:0]    mb_reg, mb_next;
    logic [63:0]      pp_reg, pp_next;
    logic [1:0]       sh_reg, sh_next;
    logic             ci_reg, ci_next;
    logic             cj_reg, cj_next;
    logic [PW-1:0]    acc_reg, acc_next;
    logic [W:0]       rem_reg, rem_next;
    logic [DW-1:0]    dvd_reg, dvd_next;
    logic [W-1:0]     ud_reg, ud_next;
    logic [CNTW-1:0]  cnt_reg, cnt_next;
    logic             neg_reg, neg_next;
    logic [W-1:0]     res_reg, res_next;
    logic             sat_reg, sat_next;

    logic [W:0]       sum;
    logic [W:0]       remsh;
    logic [PW-1:0]    pval;
    logic [PW-1:0]    plim;
    logic [DW-1:0]    dlim;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= AR_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg  <= ma_next;
        mb_reg  <= mb_next;
        pp_reg  <= pp_next;
        sh_reg  <= sh_next;
        ci_reg  <= ci_next;
        cj_reg  <= cj_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        ud_reg  <= ud_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
        sat_reg <= sat_next;
    end

    always_comb
    begin
        st_next  = st_reg;
        ma_next  = ma_reg;
        mb_next  = mb_reg;
        pp_next  = pp_reg;
        sh_next  = sh_reg;
        ci_next  = ci_reg;
        cj_next  = cj_reg;
        acc_next = acc_reg;
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        ud_next  = ud_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        res_next = res_reg;
        sat_next = sat_reg;
        sum      = '0;
        remsh    = '0;
        pval     = acc_reg >> KF3_FRAC_BITS;
        plim     = neg_reg ? (PW'(1) << (W - 1)) : PW'(VMAX);
        dlim     = neg_reg ? (DW'(1) << (W - 1)) : DW'(VMAX);

        case (st_reg)
            AR_IDLE:
            begin
                if (req.start)
                begin
                    neg_next = a[W-1] ^ b[W-1];
                    sat_next = 1'b0;
                    case (req.op)
                        OP_ADD, OP_SUB:
                        begin
                            if (req.op == OP_ADD)
                            begin
                                sum = {a[W-1], a} + {b[W-1], b};
                            end
                            else
                            begin
                                sum = {a[W-1], a} - {b[W-1], b};
                            end
                            if (sum[W] != sum[W-1])
                            begin
                                sat_next = 1'b1;
                                res_next = sum[W] ? VMIN : VMAX;
                            end
                            else
                            begin
                                res_next = sum[W-1:0];
                            end
                            st_next = AR_DONE;
                        end
                        OP_MUL:
                        begin
                            ma_next  = MW'(mag(a));
                            mb_next  = MW'(mag(b));
                            acc_next = '0;
                            ci_next  = 1'b0;
                            cj_next  = 1'b0;
                            st_next  = AR_MULP;
                        end
                        OP_DIV:
                        begin
                            if (b == '0)
                            begin
                                // zero denominator gives zero gain
                                res_next = '0;
                                st_next  = AR_DONE;
                            end
                            else
                            begin
                                dvd_next = DW'(mag(a)) << KF3_FRAC_BITS;
                                ud_next  = mag(b);
                                rem_next = '0;
                                cnt_next = CNTW'(DW);
                                st_next  = AR_DIV;
                            end
                        end
                        default:
                        begin
                            res_next = '0;
                            st_next  = AR_DONE;
                        end
                    endcase
                end
            end
            AR_MULP:
            begin
                pp_next = 64'(ma_reg[32*ci_reg +: 32]) * 64'(mb_reg[32*cj_reg +: 32]);
                sh_next = 2'(ci_reg) + 2'(cj_reg);
                st_next = AR_MULA;
            end
            AR_MULA:
            begin
                acc_next = acc_reg + (PW'(pp_reg) << (32 * sh_reg));
                st_next  = AR_MULP;
                if (cj_reg == 1'(NCH - 1))
                begin
                    cj_next = 1'b0;
                    if (ci_reg == 1'(NCH - 1))
                    begin
                        st_next = AR_MULF;
                    end
                    else
                    begin
                        ci_next = ci_reg + 1'b1;
                    end
                end
                else
                begin
                    cj_next = cj_reg + 1'b1;
                end
            end
            AR_MULF:
            begin
                if (pval > plim)
                begin
                    sat_next = 1'b1;
                    res_next = neg_reg ? VMIN : VMAX;
                end
                else
                begin
                    res_next = neg_reg ? W'(-pval[W-1:0]) : pval[W-1:0];
                end
                st_next = AR_DONE;
            end
            AR_DIV:
            begin
                // one restoring step per cycle, quotient shifts into the dividend
                remsh = {rem_reg[W-1:0], dvd_reg[DW-1]};
                if (remsh >= {1'b0, ud_reg})
                begin
                    rem_next = remsh - {1'b0, ud_reg};
                    dvd_next = {dvd_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = remsh;
                    dvd_next = {dvd_reg[DW-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    st_next = AR_DIVF;
                end
            end
            AR_DIVF:
            begin
                if (dvd_reg > dlim)
                begin
                    sat_next = 1'b1;
                    res_next = neg_reg ? VMIN : VMAX;
                end
                else
                begin
                    res_next = neg_reg ? W'(-dvd_reg[W-1:0]) : dvd_reg[W-1:0];
                end
                st_next = AR_DONE;
            end
            AR_DONE:
            begin
                st_next = AR_IDLE;
            end
            default:
            begin
                st_next = AR_IDLE;
            end
        endcase
    end

    assign rsp.done = (st_reg == AR_DONE);
    assign rsp.sat  = sat_reg;
    assign result   = res_reg;

endmodule
